[rtl/core/plcm_pkg.sv]
// ----------------------------------------------------------------------------
// Piecewise linear calibration map package
// Shared widths, codes and the types that run along the breakpoint chain.
// ----------------------------------------------------------------------------
package plcm_pkg;

	localparam int MAX_BREAKPOINTS = 16;
	localparam int SCORE_W         = 32;
	localparam int PROB_W          = 17;
	localparam int COUNT_W         = 5;
	localparam int IDX_W           = 4;
	localparam int QUOT_W          = PROB_W;
	localparam int PROD_W          = SCORE_W + PROB_W;

	localparam logic [PROB_W-1:0] PROB_ONE  = PROB_W'(65536);
	localparam logic [PROB_W-1:0] PROB_HALF = PROB_W'(32768);

	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	localparam logic [1:0] REG_EMPTY  = 2'd0;
	localparam logic [1:0] REG_FIRST  = 2'd1;
	localparam logic [1:0] REG_LAST   = 2'd2;
	localparam logic [1:0] REG_INTERP = 2'd3;

	// Per-cell position information derived from the breakpoint count.
	typedef struct packed {
		logic active;
		logic first;
		logic last;
	} plcm_ctl_t;

	// Query token that moves one cell per cycle along the chain.
	typedef struct packed {
		logic                      valid;
		logic signed [SCORE_W-1:0] score;
		logic                      le_first;
		logic                      ge_last;
		logic                      found;
		logic [PROB_W-1:0]         p_first;
		logic [PROB_W-1:0]         p_last;
		logic signed [SCORE_W-1:0] prev_s;
		logic [PROB_W-1:0]         prev_p;
		logic signed [SCORE_W-1:0] x0;
		logic signed [SCORE_W-1:0] x1;
		logic [PROB_W-1:0]         y0;
		logic [PROB_W-1:0]         y1;
	} plcm_tok_t;

endpackage

[rtl/core/plcm_cell.sv]
// ----------------------------------------------------------------------------
// Breakpoint cell
// Holds one breakpoint and updates the passing query token.
// ----------------------------------------------------------------------------
module plcm_cell (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  plcm_pkg::plcm_ctl_t                       ctl,
	input  logic                                      wr_en,
	input  logic signed [plcm_pkg::SCORE_W-1:0]       wr_score,
	input  logic [plcm_pkg::PROB_W-1:0]               wr_prob,
	input  plcm_pkg::plcm_tok_t                       tok_in,
	output plcm_pkg::plcm_tok_t                       tok_out
);

	logic signed [plcm_pkg::SCORE_W-1:0] bp_score_q;
	logic [plcm_pkg::PROB_W-1:0]         bp_prob_q;
	plcm_pkg::plcm_tok_t                 tok_nxt;
	plcm_pkg::plcm_tok_t                 tok_q;
	logic                                valid_q;
	logic                                le;
	logic                                ge;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			bp_score_q <= wr_score;
			bp_prob_q  <= wr_prob;
		end
	end

	always_comb begin
		le      = tok_in.score <= bp_score_q;
		ge      = tok_in.score >= bp_score_q;
		tok_nxt = tok_in;
		if (ctl.active) begin
			if (ctl.first) begin
				tok_nxt.le_first = le;
				tok_nxt.p_first  = bp_prob_q;
			end else if (!tok_in.found && le) begin
				// First breakpoint past the head that is at or above the query.
				tok_nxt.found = 1'b1;
				tok_nxt.x0    = tok_in.prev_s;
				tok_nxt.y0    = tok_in.prev_p;
				tok_nxt.x1    = bp_score_q;
				tok_nxt.y1    = bp_prob_q;
			end
			if (ctl.last) begin
				tok_nxt.ge_last = ge;
				tok_nxt.p_last  = bp_prob_q;
			end
			tok_nxt.prev_s = bp_score_q;
			tok_nxt.prev_p = bp_prob_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= tok_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		tok_q <= tok_nxt;
	end

	always_comb begin
		tok_out       = tok_q;
		tok_out.valid = valid_q;
	end

endmodule

[rtl/core/plcm_div.sv]
// ----------------------------------------------------------------------------
// Interpolation divider
// Restoring divider, one quotient bit per cycle, quotient known to fit.
// ----------------------------------------------------------------------------
module plcm_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [plcm_pkg::PROD_W-1:0]         num,
	input  logic [plcm_pkg::SCORE_W-1:0]        den,
	output logic                                done,
	output logic [plcm_pkg::QUOT_W-1:0]         quot
);

	localparam int CNT_W = $clog2(plcm_pkg::QUOT_W);

	logic                               run_q;
	logic                               done_q;
	logic [CNT_W-1:0]                   cnt_q;
	logic [plcm_pkg::SCORE_W-1:0]       rem_q;
	logic [plcm_pkg::QUOT_W-1:0]        quo_q;
	logic [plcm_pkg::SCORE_W-1:0]       den_q;
	logic [plcm_pkg::SCORE_W:0]         rem_sh;
	logic [plcm_pkg::SCORE_W+1:0]       diff;
	logic                               ge;

	always_comb begin
		rem_sh = {rem_q, quo_q[plcm_pkg::QUOT_W-1]};
		diff   = {1'b0, rem_sh} - {2'b00, den_q};
		ge     = !diff[plcm_pkg::SCORE_W+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(plcm_pkg::QUOT_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The upper numerator bits are already below the divisor, so only the
	// low bits produce quotient bits.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num[plcm_pkg::PROD_W-1:plcm_pkg::QUOT_W];
			quo_q <= num[plcm_pkg::QUOT_W-1:0];
			den_q <= den;
		end else if (run_q) begin
			rem_q <= ge ? diff[plcm_pkg::SCORE_W-1:0] : rem_sh[plcm_pkg::SCORE_W-1:0];
			quo_q <= {quo_q[plcm_pkg::QUOT_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

[rtl/core/piecewise_linear_calibration_map.sv]
// ----------------------------------------------------------------------------
// Piecewise linear calibration map
// Maps a raw Q16.16 score to a Q1.16 probability through a table of up to
// sixteen breakpoints, clamped at both ends and interpolated in between.
// ----------------------------------------------------------------------------
// A load transaction writes its cell when accepted and returns nothing. A query
// walks the sixteen-cell chain; clamped, empty-table and flat-segment answers
// are registered from the token leaving the chain, while interpolated ones go
// on through the multiply, divider start and bit-serial divide states.
// One query at a time (busy is high while it runs): no further query or load
// is taken until it ends; loads every cycle while the block is not busy.
// Reset clears the count to zero and the control state; the breakpoint storage
// is not cleared. Results are never stalled: done marks a one-cycle transaction.
// ----------------------------------------------------------------------------
module piecewise_linear_calibration_map (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic                                  mode,
	input  logic [plcm_pkg::IDX_W-1:0]            index,
	input  logic signed [plcm_pkg::SCORE_W-1:0]   score,
	input  logic [plcm_pkg::PROB_W-1:0]           prob,
	output logic                                  done,
	output logic [plcm_pkg::PROB_W-1:0]           probability,
	output logic [1:0]                            region,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [plcm_pkg::COUNT_W-1:0]          cfg_data
);

	localparam int NB = plcm_pkg::MAX_BREAKPOINTS;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_MUL,
		ST_DIV_GO,
		ST_DIV
	} state_t;

	state_t                               state_q;
	logic                                 busy_q;
	logic                                 done_q;
	logic [plcm_pkg::PROB_W-1:0]          probability_q;
	logic [1:0]                           region_q;
	logic [plcm_pkg::COUNT_W-1:0]         count_q;
	logic [plcm_pkg::COUNT_W-1:0]         n_eff;

	logic                                 in_acc;
	logic                                 q_acc;
	logic                                 ld_acc;
	logic [plcm_pkg::PROB_W-1:0]          wr_prob_sat;

	plcm_pkg::plcm_tok_t                  tok_c [0:NB];
	plcm_pkg::plcm_ctl_t                  ctl_c [0:NB-1];
	logic [NB-1:0]                        wr_en_c;
	logic [NB-1:0]                        tok_valid;
	plcm_pkg::plcm_tok_t                  tok_end;

	// Decision made on the token leaving the chain.
	logic                                 dec_emit;
	logic [plcm_pkg::PROB_W-1:0]          dec_prob;
	logic [1:0]                           dec_region;
	logic [plcm_pkg::SCORE_W-1:0]         dx;
	logic [plcm_pkg::SCORE_W-1:0]         dw;
	logic signed [plcm_pkg::PROB_W:0]     dy;
	logic [plcm_pkg::PROB_W-1:0]          dy_mag;

	// Interpolation operands.
	logic [plcm_pkg::SCORE_W-1:0]         dx_q;
	logic [plcm_pkg::SCORE_W-1:0]         dw_q;
	logic [plcm_pkg::PROB_W-1:0]          mag_q;
	logic                                 neg_q;
	logic [plcm_pkg::PROB_W-1:0]          y0_q;
	logic [plcm_pkg::PROD_W-1:0]          prod_q;

	logic                                 div_start;
	logic                                 div_done;
	logic [plcm_pkg::QUOT_W-1:0]          div_quot;
	logic [plcm_pkg::PROB_W-1:0]          interp_prob;

	// ------------------------------------------------------------------
	// Input transactions. A load writes one cell directly; a query enters
	// the chain as a token with all of its flags cleared.
	// ------------------------------------------------------------------
	assign in_acc = start && !busy_q;
	assign q_acc  = in_acc && (mode == plcm_pkg::MODE_QUERY);
	assign ld_acc = in_acc && (mode == plcm_pkg::MODE_LOAD);

	// Probabilities above one are saturated as they are stored.
	assign wr_prob_sat = (prob > plcm_pkg::PROB_ONE) ? plcm_pkg::PROB_ONE : prob;

	// Counts beyond the table size use the whole table.
	assign n_eff = (count_q > plcm_pkg::COUNT_W'(NB)) ? plcm_pkg::COUNT_W'(NB) : count_q;

	always_comb begin
		tok_c[0]       = '0;
		tok_c[0].valid = q_acc;
		tok_c[0].score = score;
	end

	// ------------------------------------------------------------------
	// The breakpoint chain. Cell i holds breakpoint i; the token moves one
	// cell per cycle and collects the first and last breakpoints and the
	// segment that brackets the query.
	// ------------------------------------------------------------------
	for (genvar i = 0; i < NB; i++) begin : g_cell
		assign ctl_c[i].active = n_eff > plcm_pkg::COUNT_W'(i);
		assign ctl_c[i].first  = (i == 0);
		assign ctl_c[i].last   = n_eff == plcm_pkg::COUNT_W'(i + 1);
		assign wr_en_c[i]      = ld_acc && (index == plcm_pkg::IDX_W'(i));
		assign tok_valid[i]    = tok_c[i+1].valid;

		plcm_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl_c[i]),
			.wr_en    (wr_en_c[i]),
			.wr_score (score),
			.wr_prob  (wr_prob_sat),
			.tok_in   (tok_c[i]),
			.tok_out  (tok_c[i+1])
		);
	end

	assign tok_end = tok_c[NB];

	// ------------------------------------------------------------------
	// Region selection. The checks follow the priority of the mapping:
	// empty table, at or below the first score, at or above the last score,
	// then the bracketing segment. An unordered table with no bracketing
	// segment falls back to the last breakpoint. A segment of zero or
	// negative width answers with its lower probability.
	// ------------------------------------------------------------------
	always_comb begin
		dx     = tok_end.score - tok_end.x0;
		dw     = tok_end.x1 - tok_end.x0;
		dy     = $signed({1'b0, tok_end.y1}) - $signed({1'b0, tok_end.y0});
		dy_mag = dy[plcm_pkg::PROB_W] ? plcm_pkg::PROB_W'(-dy) : dy[plcm_pkg::PROB_W-1:0];

		dec_emit   = 1'b1;
		dec_prob   = tok_end.p_last;
		dec_region = plcm_pkg::REG_LAST;
		if (n_eff == '0) begin
			dec_prob   = plcm_pkg::PROB_HALF;
			dec_region = plcm_pkg::REG_EMPTY;
		end else if (tok_end.le_first) begin
			dec_prob   = tok_end.p_first;
			dec_region = plcm_pkg::REG_FIRST;
		end else if (tok_end.ge_last) begin
			dec_prob   = tok_end.p_last;
			dec_region = plcm_pkg::REG_LAST;
		end else if (tok_end.found) begin
			dec_region = plcm_pkg::REG_INTERP;
			dec_prob   = tok_end.y0;
			dec_emit   = !(tok_end.x1 > tok_end.x0);
		end
	end

	// The query lies strictly above x0 and at or below x1, so the offset is
	// no wider than the segment and the quotient never exceeds the
	// probability step; the result stays between the two end probabilities.
	always_ff @(posedge clk) begin
		if (state_q == ST_SEARCH && tok_end.valid) begin
			dx_q  <= dx;
			dw_q  <= dw;
			mag_q <= dy_mag;
			neg_q <= dy[plcm_pkg::PROB_W];
			y0_q  <= tok_end.y0;
		end
		if (state_q == ST_MUL) begin
			prod_q <= plcm_pkg::PROD_W'(dx_q) * plcm_pkg::PROD_W'(mag_q);
		end
	end

	assign div_start = (state_q == ST_DIV_GO);

	plcm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (prod_q),
		.den    (dw_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	// Truncation toward zero: the magnitude is divided, then the sign applied.
	assign interp_prob = neg_q ? (y0_q - div_quot) : (y0_q + div_quot);

	// ------------------------------------------------------------------
	// Sequencer and result registers.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			busy_q        <= 1'b0;
			done_q        <= 1'b0;
			probability_q <= '0;
			region_q      <= plcm_pkg::REG_EMPTY;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (q_acc) begin
						busy_q  <= 1'b1;
						state_q <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					if (tok_end.valid) begin
						if (dec_emit) begin
							done_q        <= 1'b1;
							busy_q        <= 1'b0;
							probability_q <= dec_prob;
							region_q      <= dec_region;
							state_q       <= ST_IDLE;
						end else begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					state_q <= ST_DIV_GO;
				end
				ST_DIV_GO: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						done_q        <= 1'b1;
						busy_q        <= 1'b0;
						probability_q <= interp_prob;
						region_q      <= plcm_pkg::REG_INTERP;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	// The count register is only written between queries.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			count_q <= cfg_data;
		end
	end

	assign cfg_ready   = !busy_q;
	assign busy        = busy_q;
	assign done        = done_q;
	assign probability = probability_q;
	assign region      = region_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------

	// A query ends only by delivering its result.
	a_busy_ends_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> done_q)
		else $error("busy dropped without a result");

	// At most one token is in the chain, and only while searching.
	a_single_token: assert property (@(posedge clk) disable iff (!arst_n)
		(|tok_valid) |-> ($countones(tok_valid) == 1 && state_q == ST_SEARCH))
		else $error("chain token out of step with the sequencer");

	// The divider finishes only while the sequencer waits for it.
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside its wait state");

	// An empty table always answers one half.
	a_empty_half: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && region_q == plcm_pkg::REG_EMPTY) |-> probability_q == plcm_pkg::PROB_HALF)
		else $error("empty-table result is not one half");

endmodule

[bench/piecewise_linear_calibration_map_tb.sv]
// ----------------------------------------------------------------------------
// Piecewise linear calibration map testbench
// Loads breakpoint tables, sets the breakpoint count between phases and sends
// score queries. Every query answer is checked, field by field, against a
// behavioral predictor that is kept in step at each accepted transaction.
// ----------------------------------------------------------------------------
module piecewise_linear_calibration_map_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// The longest legal quiet stretch is the settle pause before a count
	// write, one interpolated query and a long sender gap. The limit below
	// is many times that.
	localparam int WATCHDOG_LIMIT = 4000;
	// Loads give no answer, so a query may still be running when nothing is
	// expected. This pause covers the slowest query before a count write.
	localparam int SETTLE_CYCLES  = 48;
	localparam int TARGET_ITEMS   = 1200;
	localparam int REPORT_LIMIT   = 10;

	typedef struct packed {
		logic                                mode;
		logic [plcm_pkg::IDX_W-1:0]          index;
		logic signed [plcm_pkg::SCORE_W-1:0] score;
		logic [plcm_pkg::PROB_W-1:0]         prob;
	} cal_item_t;

	typedef struct packed {
		logic [plcm_pkg::PROB_W-1:0] probability;
		logic [1:0]                  region;
	} calib_t;

	// Block ports.
	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                start = 1'b0;
	logic                                busy;
	logic                                mode = plcm_pkg::MODE_LOAD;
	logic [plcm_pkg::IDX_W-1:0]          index = '0;
	logic signed [plcm_pkg::SCORE_W-1:0] score = '0;
	logic [plcm_pkg::PROB_W-1:0]         prob = '0;
	logic                                done;
	logic [plcm_pkg::PROB_W-1:0]         probability;
	logic [1:0]                          region;
	logic                                cfg_valid = 1'b0;
	logic                                cfg_ready;
	logic [plcm_pkg::COUNT_W-1:0]        cfg_data = '0;

	// Transactions waiting for the driver, and the answers still owed by the block.
	cal_item_t pending_items[$];
	calib_t    expected_maps[$];

	// Predictor state: the breakpoint table and count as the block holds them.
	logic signed [plcm_pkg::SCORE_W-1:0] bp_score[plcm_pkg::MAX_BREAKPOINTS];
	logic [plcm_pkg::PROB_W-1:0]         bp_prob[plcm_pkg::MAX_BREAKPOINTS];
	logic [plcm_pkg::COUNT_W-1:0]        bp_count = '0;

	// Stimulus planning copy of the table, used only to aim query scores.
	logic signed [plcm_pkg::SCORE_W-1:0] plan_score[plcm_pkg::MAX_BREAKPOINTS];
	int                                  plan_n = 0;

	int items_planned = 0;
	int items_accepted = 0;
	int loads_seen = 0;
	int queries_seen = 0;
	int count_writes = 0;
	int mismatches = 0;
	int region_hits[4] = '{0, 0, 0, 0};
	int quiet_cycles = 0;

	piecewise_linear_calibration_map u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.index(index),
		.score(score),
		.prob(prob),
		.done(done),
		.probability(probability),
		.region(region),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------

	// Maps a query score through the current table: empty table, clamp at the
	// first or the last breakpoint, or linear interpolation inside the first
	// segment whose upper score reaches the query. The quotient truncates
	// toward zero, a segment of zero width answers its lower probability, and
	// the answer is clamped to the probability range.
	function automatic calib_t map_score(input logic signed [plcm_pkg::SCORE_W-1:0] q);
		calib_t res;
		int     n;
		longint x0, x1, y0, y1, r;
		bit     hit;
		n = (bp_count > plcm_pkg::MAX_BREAKPOINTS) ? plcm_pkg::MAX_BREAKPOINTS
			: int'(bp_count);
		hit = 1'b0;
		res.probability = plcm_pkg::PROB_HALF;
		res.region = plcm_pkg::REG_EMPTY;
		if (n == 0)
			return res;
		if (q <= bp_score[0]) begin
			res.probability = bp_prob[0];
			res.region = plcm_pkg::REG_FIRST;
			return res;
		end
		// An unordered table where no segment is found also ends here.
		res.probability = bp_prob[n-1];
		res.region = plcm_pkg::REG_LAST;
		if (q >= bp_score[n-1])
			return res;
		for (int i = 1; i < n; i++) begin
			if (!hit && q <= bp_score[i]) begin
				hit = 1'b1;
				x0 = longint'(bp_score[i-1]);
				x1 = longint'(bp_score[i]);
				y0 = longint'(bp_prob[i-1]);
				y1 = longint'(bp_prob[i]);
				r = y0;
				if (x1 > x0)
					r = y0 + ((longint'(q) - x0) * (y1 - y0)) / (x1 - x0);
				if (r < 0)
					r = 0;
				if (r > longint'(plcm_pkg::PROB_ONE))
					r = longint'(plcm_pkg::PROB_ONE);
				res.probability = plcm_pkg::PROB_W'(r);
				res.region = plcm_pkg::REG_INTERP;
			end
		end
		return res;
	endfunction

	// Folds one accepted transaction into the predictor. A load stores the
	// breakpoint with its probability saturated at one; a query owes an answer.
	task automatic apply_item(input cal_item_t it);
		calib_t want;
		if (it.mode == plcm_pkg::MODE_LOAD) begin
			bp_score[it.index] = it.score;
			bp_prob[it.index] = (it.prob > plcm_pkg::PROB_ONE) ? plcm_pkg::PROB_ONE : it.prob;
			loads_seen++;
		end else begin
			want = map_score(it.score);
			expected_maps = {expected_maps, want};
			region_hits[want.region]++;
			queries_seen++;
		end
	endtask

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= REPORT_LIMIT)
			$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	// ------------------------------------------------------------------------
	// Driver: presents queued transactions on start, holding each one until
	// the block is not busy. The sender idles at random in a rate that changes
	// with progress: light idling, then heavy idling, then none.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		cal_item_t nxt;
		int        idle_pct;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				apply_item('{mode, index, score, prob});
				items_accepted++;
			end
			// A transaction that is still waiting stays on the ports untouched.
			if (!start || !busy) begin
				if (items_accepted < TARGET_ITEMS / 3)
					idle_pct = 14;
				else if (items_accepted < 2 * TARGET_ITEMS / 3)
					idle_pct = 84;
				else
					idle_pct = 0;
				if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
					nxt = pending_items[0];
					pending_items.delete(0);
					start <= 1'b1;
					mode <= nxt.mode;
					index <= nxt.index;
					score <= nxt.score;
					prob <= nxt.prob;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: every done strobe is one answer transaction. It must match the
	// oldest owed answer in both fields.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		calib_t want;
		if (arst_n && done) begin
			if (expected_maps.size() == 0) begin
				report_mismatch($sformatf("answer with none owed: probability %0d region %0d",
					probability, region));
			end else begin
				want = expected_maps[0];
				expected_maps.delete(0);
				if (probability !== want.probability || region !== want.region)
					report_mismatch($sformatf(
						"expected probability %0d region %0d, got probability %0d region %0d",
						want.probability, want.region, probability, region));
			end
		end
	end

	// Watchdog: counts cycles in which no transaction of any kind completes.
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[%0t] watchdog: no transaction for %0d cycles, %0d answers owed",
				$realtime, quiet_cycles, expected_maps.size());
			$display("** piecewise_linear_calibration_map: FAILED **");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------

	// Appends one transaction to the driver's queue.
	task automatic queue_item(input cal_item_t it);
		pending_items = {pending_items, it};
		items_planned++;
	endtask

	task automatic push_load(input int slot, input logic [plcm_pkg::SCORE_W-1:0] s,
		input logic [plcm_pkg::PROB_W-1:0] p);
		queue_item('{plcm_pkg::MODE_LOAD, plcm_pkg::IDX_W'(slot), s, p});
		plan_score[slot] = s;
	endtask

	// Index and probability are don't-cares on a query, so they carry noise.
	task automatic push_query(input logic [plcm_pkg::SCORE_W-1:0] s);
		queue_item('{plcm_pkg::MODE_QUERY, plcm_pkg::IDX_W'($urandom), s,
			plcm_pkg::PROB_W'($urandom)});
	endtask

	// Waits until the block is idle: nothing queued, nothing on the ports,
	// nothing owed. Checked on the falling edge, where everything has settled.
	task automatic drain();
		do
			@(negedge clk);
		while (pending_items.size() != 0 || start || busy || expected_maps.size() != 0);
	endtask

	// Writes the breakpoint count through its own channel while the block is idle.
	task automatic set_count(input int val);
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= plcm_pkg::COUNT_W'(val);
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		bp_count = plcm_pkg::COUNT_W'(val);
		cfg_valid <= 1'b0;
		plan_n = (val > plcm_pkg::MAX_BREAKPOINTS) ? plcm_pkg::MAX_BREAKPOINTS : val;
		count_writes++;
	endtask

	// Aims a query score at the interesting places of the planned table:
	// exact breakpoints, their neighbors, inside a segment, the score extremes, or anywhere.
	function automatic logic [plcm_pkg::SCORE_W-1:0] pick_score();
		int     k;
		longint lo, hi, off;
		k = $urandom_range((plan_n > 0) ? plan_n - 1 : 0, 0);
		case ($urandom_range(9))
			0: return $urandom;
			1: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
			2, 3: return plan_score[k];
			4: return $urandom_range(1) ? plan_score[k] + 32'sd1 : plan_score[k] - 32'sd1;
			default: begin
				if (plan_n < 2)
					return $urandom;
				k = $urandom_range(plan_n - 2, 0);
				lo = longint'(plan_score[k]);
				hi = longint'(plan_score[k+1]);
				if (lo > hi) begin
					off = lo;
					lo = hi;
					hi = off;
				end
				off = longint'({$urandom, $urandom} >> 1);
				return plcm_pkg::SCORE_W'(lo + off % (hi - lo + 1));
			end
		endcase
	endfunction

	// Loads all sixteen slots. Kinds: wide ordered scores, narrow ordered
	// scores with repeated values, ordered scores reaching both score
	// extremes, and an unordered table. Ordered tables get ascending
	// probabilities; a few probabilities above one test saturation on load.
	task automatic load_table(input int kind);
		longint                      s[plcm_pkg::MAX_BREAKPOINTS];
		logic [plcm_pkg::PROB_W-1:0] p[plcm_pkg::MAX_BREAKPOINTS];
		longint                      t;
		logic [plcm_pkg::PROB_W-1:0] tp;
		int                          up, slot;
		for (int i = 0; i < plcm_pkg::MAX_BREAKPOINTS; i++) begin
			if (kind == 1)
				s[i] = (i == 0) ? (longint'($signed($urandom)) >>> 2)
					: s[i-1] + ($urandom_range(3) == 0 ? 0 : $urandom_range(1 << 20, 1));
			else
				s[i] = longint'($signed($urandom));
			p[i] = plcm_pkg::PROB_W'($urandom_range(plcm_pkg::PROB_ONE));
		end
		if (kind != 3) begin
			for (int i = 0; i < plcm_pkg::MAX_BREAKPOINTS - 1; i++)
				for (int j = 0; j < plcm_pkg::MAX_BREAKPOINTS - 1 - i; j++) begin
					if (s[j] > s[j+1]) begin
						t = s[j];
						s[j] = s[j+1];
						s[j+1] = t;
					end
					if (p[j] > p[j+1]) begin
						tp = p[j];
						p[j] = p[j+1];
						p[j+1] = tp;
					end
				end
		end
		if (kind == 2) begin
			s[0] = -64'sd2147483648;
			if (plan_n >= 2)
				s[plan_n-1] = 64'sd2147483647;
		end
		for (int i = 0; i < plcm_pkg::MAX_BREAKPOINTS; i++)
			if ($urandom_range(7) == 0)
				p[i] = plcm_pkg::PROB_W'($urandom_range(131071, 65537));
		up = $urandom_range(1);
		for (int j = 0; j < plcm_pkg::MAX_BREAKPOINTS; j++) begin
			slot = up ? j : plcm_pkg::MAX_BREAKPOINTS - 1 - j;
			push_load(slot, plcm_pkg::SCORE_W'(s[slot]), p[slot]);
		end
	endtask

	initial begin
		int seq_counts[12];
		int phase, cnt, kind_sel, nq;

		seq_counts = '{2, 16, 1, 31, 0, 17, 5, 16, 3, 9, 16, 12};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. With the count at its reset value of zero every query
		// answers one half, whatever the score.
		push_query(32'h8000_0000);
		push_query(32'h7FFF_FFFF);
		push_query(32'h0000_0000);
		// An ordered table that spans the whole score range. The last slot is
		// loaded with a probability above one, which must saturate.
		for (int i = 0; i < plcm_pkg::MAX_BREAKPOINTS; i++) begin
			if (i == 0)
				push_load(i, 32'h8000_0000, '0);
			else if (i == plcm_pkg::MAX_BREAKPOINTS - 1)
				push_load(i, 32'h7FFF_FFFF, 17'h1FFFF);
			else
				push_load(i, plcm_pkg::SCORE_W'((i - 7) * 32'sh0100_0000),
					plcm_pkg::PROB_W'(i * 4096));
		end
		// A single breakpoint: at or below it the first clamp applies.
		set_count(1);
		push_query(32'h8000_0000);
		push_query(32'h0000_0000);
		// Full table: both clamps, interpolation across the widest segments at
		// both ends, and a query landing exactly on an inner breakpoint.
		set_count(16);
		push_query(32'h8000_0000);
		push_query(32'h7FFF_FFFF);
		push_query(32'h8000_0001);
		push_query(32'h7FFF_FFFE);
		push_query(32'h0000_0000);
		// A count above the table size acts as a full table.
		set_count(31);
		push_query(32'h0080_0000);

		// Random phases: a count setting, a fresh table, then mostly aimed
		// queries with the odd stray load that may break the ordering.
		phase = 0;
		while (items_planned < TARGET_ITEMS) begin
			if (phase < 12)
				cnt = seq_counts[phase];
			else if ($urandom_range(9) == 0)
				cnt = $urandom_range(31, 17);
			else if ($urandom_range(9) == 0)
				cnt = $urandom_range(1);
			else
				cnt = $urandom_range(16, 2);
			set_count(cnt);
			kind_sel = $urandom_range(7);
			load_table(kind_sel < 3 ? 0 : kind_sel < 5 ? 1 : kind_sel < 7 ? 2 : 3);
			nq = $urandom_range(80, 30);
			repeat (nq) begin
				if ($urandom_range(19) == 0)
					push_load($urandom_range(plcm_pkg::MAX_BREAKPOINTS - 1), $urandom,
						plcm_pkg::PROB_W'($urandom));
				else
					push_query(pick_score());
			end
			phase++;
		end

		// Let the last answers arrive, then watch a while for stray strobes.
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Run covered %0d loads, %0d queries and %0d count writes; %0d mismatches.",
			loads_seen, queries_seen, count_writes, mismatches);
		$display("Answers by region: empty %0d, first %0d, last %0d, interpolated %0d.",
			region_hits[plcm_pkg::REG_EMPTY], region_hits[plcm_pkg::REG_FIRST],
			region_hits[plcm_pkg::REG_LAST], region_hits[plcm_pkg::REG_INTERP]);
		if (mismatches == 0 && expected_maps.size() == 0)
			$display("** piecewise_linear_calibration_map: PASSED **");
		else
			$display("** piecewise_linear_calibration_map: FAILED **");
		$finish;
	end

endmodule
